// File: rtl/core/i2a_pkg.sv
// Package with shared widths, types and the digit glyph function for the ASCII converter.
`default_nettype none
package i2a_pkg;
	localparam int ValueW = 64;
	localparam int NumCells = 20;
	localparam int CntW = 5;
	localparam int BitCntW = 6;

	typedef logic [3:0] digit_t;

	// Sequencer states of the converter.
	typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_SCAN, ST_EMIT} state_t;

	// Shift-and-add-3 control handed from the sequencer to the cell row.
	typedef struct packed {
		logic clear;
		logic shift;
	} cell_ctl_t;

	function automatic logic [6:0] glyph(input digit_t d);
		logic [6:0] r;
		if (d < 4'd10) begin
			r = 7'h30 + {3'b000, d};
		end else begin
			r = 7'h37 + {3'b000, d};
		end
		return r;
	endfunction
endpackage
`default_nettype wire

// File: rtl/core/integer_to_ascii_digits.sv
// Top level of the binary to ASCII decimal or hexadecimal converter.
// Sequence: a decimal beat runs the conversion and then a scan cycle before its first character
// is emitted; a hexadecimal beat goes straight from acceptance to emission.
// Throughput: one beat at a time; characters go out one per cycle while the output does not stall.
// Reset clears the sequencer and all cells; the value and output data need no reset.
`default_nettype none
module integer_to_ascii_digits (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic                         action,
	input  wire logic [i2a_pkg::ValueW-1:0]   value,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [6:0]                        char_code,
	output logic                              last
);
	i2a_pkg::state_t state_q, state_d;
	logic [i2a_pkg::ValueW-1:0] val_q;
	logic hex_q;
	logic [i2a_pkg::BitCntW-1:0] bit_q;
	logic [i2a_pkg::CntW-1:0] idx_q;
	logic [i2a_pkg::CntW-1:0] top_d;
	logic out_valid_q;
	logic [6:0] char_q;
	logic last_q;
	i2a_pkg::cell_ctl_t ctl;
	logic [i2a_pkg::NumCells:0] carry;
	i2a_pkg::digit_t digits [i2a_pkg::NumCells];
	i2a_pkg::digit_t cur_digit;
	logic accept_in, out_free, emit_now;

	assign accept_in = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != i2a_pkg::ST_IDLE);
	assign emit_now = (state_q == i2a_pkg::ST_EMIT) && out_free;

	// The cell row shifts in the value MSB first, one bit per conversion cycle.
	always_comb begin
		ctl.clear = accept_in;
		ctl.shift = (state_q == i2a_pkg::ST_CONV);
	end
	assign carry[0] = val_q[i2a_pkg::ValueW-1];

	for (genvar g = 0; g < i2a_pkg::NumCells; g++) begin : g_cell
		i2a_cell u_cell (
			.clk(clk), .arst_n(arst_n), .ctl(ctl),
			.carry_in(carry[g]), .carry_out(carry[g+1]), .digit(digits[g])
		);
	end

	// Highest nonzero digit picks where emission starts; zero gives one digit.
	// It is sampled in the scan cycle, once the last shift has settled in the row.
	always_comb begin
		top_d = '0;
		for (int i = 0; i < i2a_pkg::NumCells; i++) begin
			if (digits[i] != 4'd0) top_d = i2a_pkg::CntW'(i);
		end
	end

	always_comb begin
		if (hex_q) cur_digit = val_q[4*idx_q[3:0] +: 4];
		else cur_digit = digits[idx_q];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			i2a_pkg::ST_IDLE: if (accept_in) state_d = action ? i2a_pkg::ST_EMIT
				: i2a_pkg::ST_CONV;
			i2a_pkg::ST_CONV: if (bit_q == '1) state_d = i2a_pkg::ST_SCAN;
			i2a_pkg::ST_SCAN: state_d = i2a_pkg::ST_EMIT;
			i2a_pkg::ST_EMIT: if (emit_now && idx_q == '0) state_d = i2a_pkg::ST_IDLE;
			default: state_d = i2a_pkg::ST_IDLE;
		endcase
	end

	logic [3:0] hex_top;
	always_comb begin
		hex_top = '0;
		for (int i = 0; i < 16; i++) begin
			if (value[4*i +: 4] != 4'd0) hex_top = 4'(i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= i2a_pkg::ST_IDLE;
			bit_q <= '0;
			idx_q <= '0;
			hex_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_free) out_valid_q <= emit_now;
			if (accept_in) begin
				hex_q <= action;
				bit_q <= '0;
				idx_q <= {1'b0, hex_top};
			end else if (state_q == i2a_pkg::ST_CONV) begin
				bit_q <= bit_q + 1'b1;
			end else if (state_q == i2a_pkg::ST_SCAN) begin
				idx_q <= top_d;
			end else if (emit_now) begin
				idx_q <= idx_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) val_q <= value;
		else if (state_q == i2a_pkg::ST_CONV) val_q <= {val_q[i2a_pkg::ValueW-2:0], 1'b0};
		if (emit_now) begin
			char_q <= i2a_pkg::glyph(cur_digit);
			last_q <= (idx_q == '0);
		end
	end

	assign out_valid = out_valid_q;
	assign char_code = char_q;
	assign last = last_q;

	// No new beat is taken while a conversion is under way.
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == i2a_pkg::ST_CONV) |-> !accept_in) else $error("accept during conversion");
	// A delivered character is always a legal digit glyph.
	a_glyph: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((char_code >= 7'h30 && char_code <= 7'h39) ||
		(char_code >= 7'h41 && char_code <= 7'h46))) else $error("bad glyph");
	// Conversion always ends in the scan cycle.
	a_conv_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == i2a_pkg::ST_CONV && bit_q == '1) |=> state_q == i2a_pkg::ST_SCAN)
		else $error("conv end");
endmodule
`default_nettype wire

// File: rtl/core/i2a_cell.sv
// One BCD digit cell of the double-dabble shift chain.
`default_nettype none
module i2a_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire i2a_pkg::cell_ctl_t ctl,
	input  wire logic              carry_in,
	output logic                   carry_out,
	output i2a_pkg::digit_t        digit
);
	i2a_pkg::digit_t digit_q;
	i2a_pkg::digit_t adj;

	// Add three before the shift when the digit is five or more.
	always_comb begin
		adj = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
	end

	assign carry_out = adj[3];
	assign digit = digit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
		end else if (ctl.clear) begin
			digit_q <= '0;
		end else if (ctl.shift) begin
			digit_q <= {adj[2:0], carry_in};
		end
	end
endmodule
`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for the integer to ASCII digit converter.
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// Radix select codes carried in the action field.
	localparam logic RADIX_DEC = 1'b0;
	localparam logic RADIX_HEX = 1'b1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic action = RADIX_DEC;
	logic [63:0] value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [6:0] char_code;
	logic last;

	// One expected character: its ASCII code and whether it closes the number.
	typedef struct packed {
		logic [6:0] code;
		logic       fin;
	} char_exp_t;

	char_exp_t pending_chars[$];
	int err_count = 0;
	bit idle_enable = 1'b0;
	bit hold_request = 1'b0;

	integer_to_ascii_digits dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .value(value),
		.out_valid(out_valid), .out_stall(out_stall),
		.char_code(char_code), .last(last)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Predict the digit string of one number, most significant digit first, and
	// queue it. Zero still yields one digit because the loop runs at least once.
	function automatic void predict_digits(input logic hex, input logic [63:0] num);
		logic [6:0] rev[20];
		int n;
		logic [63:0] v;
		logic [3:0] d;
		n = 0;
		v = num;
		do begin
			if (hex) begin
				d = v[3:0];
				v = v >> 4;
			end else begin
				d = 4'(v % 64'd10);
				v = v / 64'd10;
			end
			rev[n] = (d < 4'd10) ? 7'h30 + 7'(d) : 7'h37 + 7'(d);
			n++;
		end while (v != 0 && n < 20);
		for (int k = n - 1; k >= 0; k--) begin
			pending_chars.push_back('{code: rev[k], fin: (k == 0)});
		end
	endfunction

	// Offer one beat and hold it until accepted. The sender idles at random
	// before the beat when idling is enabled; valid never looks at stall.
	// Valid stays high after acceptance so that a following beat can go out
	// back to back; whoever idles or finishes drops it.
	task automatic send_number(input logic hex, input logic [63:0] num);
		while (idle_enable && $urandom_range(99) < 7) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= hex;
		value <= num;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		predict_digits(hex, num);
	endtask

	// Receiver stall pattern. A long hold-off can be requested by a test, which
	// fills the block while the sender keeps offering beats.
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				out_stall <= 1'b1;
				for (int c = 0; c < 400; c++) begin
					@(posedge clk);
				end
				hold_request = 1'b0;
				out_stall <= 1'b0;
			end else begin
				out_stall <= idle_enable && ($urandom_range(99) < 7);
			end
		end
	end

	// Compare every accepted output beat with the oldest predicted character.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_chars.size() == 0) begin
				$error("unexpected beat: char_code=%0h last=%0b", char_code, last);
				err_count++;
			end else begin
				char_exp_t e;
				e = pending_chars.pop_front();
				if (char_code !== e.code) begin
					$error("char_code: expected %0h actual %0h", e.code, char_code);
					err_count++;
				end
				if (last !== e.fin) begin
					$error("last: expected %0b actual %0b", e.fin, last);
					err_count++;
				end
			end
		end
	end

	// Extremes of both radixes, zero, single digits, the top value bit alone and alternating bit patterns.
	task automatic test_directed();
		send_number(RADIX_DEC, 64'd0);
		send_number(RADIX_HEX, 64'd0);
		send_number(RADIX_DEC, '1);
		send_number(RADIX_HEX, '1);
		send_number(RADIX_DEC, 64'd9);
		send_number(RADIX_DEC, 64'd10);
		send_number(RADIX_HEX, 64'd15);
		send_number(RADIX_HEX, 64'd16);
		send_number(RADIX_DEC, 64'd10000000000000000000);
		send_number(RADIX_DEC, 64'd9999999999999999999);
		send_number(RADIX_HEX, 64'h0123456789ABCDEF);
		send_number(RADIX_HEX, 64'hFEDCBA9876543210);
		send_number(RADIX_DEC, 64'h8000000000000000);
		send_number(RADIX_HEX, 64'h8000000000000000);
		send_number(RADIX_DEC, 64'h5555555555555555);
		send_number(RADIX_HEX, 64'hAAAAAAAAAAAAAAAA);
	endtask

	// Random values with random magnitudes so short and long strings both occur.
	task automatic test_random(input int count);
		logic [63:0] v;
		int sh;
		for (int i = 0; i < count; i++) begin
			v = {$urandom, $urandom};
			sh = $urandom_range(63);
			v = v >> sh;
			send_number(1'($urandom_range(1)), v);
		end
	endtask

	// The receiver holds off for a long time while beats keep coming.
	task automatic test_backpressure();
		hold_request = 1'b1;
		test_random(10);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(60);
		idle_enable = 1'b1;
		test_random(120);
		test_backpressure();
		in_valid <= 1'b0;
		while (pending_chars.size() != 0) begin
			@(posedge clk);
		end
		repeat (100) @(posedge clk);
		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// Around 210 beats, stalls and the long hold-off included, fit easily in this time limit.
	initial begin
		#5ms;
		$display("DONE: errors detected");
		$finish;
	end
endmodule
`default_nettype wire

// File: sim.f
rtl/core/i2a_pkg.sv
rtl/core/i2a_cell.sv
rtl/core/integer_to_ascii_digits.sv
tb/tb_top.sv
